>>> rtl/mf3_pkg.sv
package mf3_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int CHANNEL_BITS = 8;
	localparam int WINDOW       = 3;
	localparam int TAPS         = WINDOW * WINDOW;
	localparam int COL_BITS     = $clog2(MAX_WIDTH);
	localparam int ROW_BITS     = 12;
	localparam int CFG_BITS     = 12;
	localparam int CFG_ADDR_BITS = 4;
	localparam int PIX_BITS     = 3 * CHANNEL_BITS;

	localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH  = CFG_ADDR_BITS'(0);
	localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT = CFG_ADDR_BITS'(1);

	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	typedef logic [CHANNEL_BITS-1:0] chan_t;
	typedef logic [TAPS-1:0][CHANNEL_BITS-1:0] chan9_t;
	typedef logic [PIX_BITS-1:0] pix_t;
	typedef logic [TAPS-1:0][PIX_BITS-1:0] pix9_t;

	typedef struct packed {
		pix_t prev;
		pix_t prev2;
	} rows_t;

	typedef struct packed {
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
		logic                c_is0;
		logic                c_is1;
		logic                c_last;
		logic                r_is0;
		logic                r_is1;
		logic                r_last;
	} pos_t;

	typedef struct packed {
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
		logic                run_last;
		logic                frame_last;
	} meta_t;

	function automatic chan9_t med_cswap(chan9_t p, int lo, int hi);
		chan9_t q;
		q = p;
		if (p[lo] > p[hi]) begin
			q[lo] = p[hi];
			q[hi] = p[lo];
		end
		return q;
	endfunction

	// The three rows of the window are sorted first.
	function automatic chan9_t med_pass_a(chan9_t p);
		chan9_t q;
		q = p;
		q = med_cswap(q, 1, 2);
		q = med_cswap(q, 4, 5);
		q = med_cswap(q, 7, 8);
		q = med_cswap(q, 0, 1);
		q = med_cswap(q, 3, 4);
		q = med_cswap(q, 6, 7);
		q = med_cswap(q, 1, 2);
		q = med_cswap(q, 4, 5);
		q = med_cswap(q, 7, 8);
		return q;
	endfunction

	function automatic chan9_t med_pass_b(chan9_t p);
		chan9_t q;
		q = p;
		q = med_cswap(q, 0, 3);
		q = med_cswap(q, 5, 8);
		q = med_cswap(q, 4, 7);
		q = med_cswap(q, 3, 6);
		q = med_cswap(q, 1, 4);
		q = med_cswap(q, 2, 5);
		return q;
	endfunction

	function automatic chan_t med_pass_c(chan9_t p);
		chan9_t q;
		q = p;
		q = med_cswap(q, 4, 7);
		q = med_cswap(q, 4, 2);
		q = med_cswap(q, 6, 4);
		q = med_cswap(q, 4, 2);
		return q[4];
	endfunction

endpackage

>>> rtl/mf3_if.sv
interface mf3_pix_if;
	logic                          valid;
	logic                          ready;
	logic [mf3_pkg::CHANNEL_BITS-1:0] in_red;
	logic [mf3_pkg::CHANNEL_BITS-1:0] in_green;
	logic [mf3_pkg::CHANNEL_BITS-1:0] in_blue;

	modport source (output valid, in_red, in_green, in_blue, input ready);
	modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface mf3_med_if;
	logic                          valid;
	logic                          ready;
	logic [mf3_pkg::CHANNEL_BITS-1:0] med_red;
	logic [mf3_pkg::CHANNEL_BITS-1:0] med_green;
	logic [mf3_pkg::CHANNEL_BITS-1:0] med_blue;
	logic [mf3_pkg::COL_BITS-1:0]     out_col;
	logic [mf3_pkg::ROW_BITS-1:0]     out_row;
	logic                          run_last;
	logic                          frame_last;

	modport source (output valid, med_red, med_green, med_blue, out_col, out_row,
		run_last, frame_last, input ready);
	modport sink (input valid, med_red, med_green, med_blue, out_col, out_row,
		run_last, frame_last, output ready);
endinterface

interface mf3_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mf3_pkg::CFG_ADDR_BITS-1:0] addr;
	logic [mf3_pkg::CFG_BITS-1:0]      data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

>>> rtl/mf3_line_buf.sv
module mf3_line_buf (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [mf3_pkg::COL_BITS-1:0]  rd_addr,
	input  logic                          wr_en,
	input  logic [mf3_pkg::COL_BITS-1:0]  wr_addr,
	input  mf3_pkg::rows_t                wr_data,
	output mf3_pkg::rows_t                rd_data
);

	mf3_pkg::rows_t mem [mf3_pkg::MAX_WIDTH];
	mf3_pkg::rows_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A write in the same cycle to the same column is forwarded.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

>>> rtl/mf3_median_lane.sv
module mf3_median_lane (
	input  logic            clk,
	input  logic            en,
	input  mf3_pkg::chan9_t vals,
	output mf3_pkg::chan_t  med
);

	mf3_pkg::chan9_t a_s3;
	mf3_pkg::chan9_t b_s4;
	mf3_pkg::chan_t  med_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3   <= mf3_pkg::med_pass_a(vals);
			b_s4   <= mf3_pkg::med_pass_b(a_s3);
			med_s5 <= mf3_pkg::med_pass_c(b_s4);
		end
	end

	assign med = med_s5;

endmodule

>>> rtl/mf3_window.sv
module mf3_window (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  mf3_pkg::pix_t  px,
	input  mf3_pkg::pix_t  up,
	input  mf3_pkg::pix_t  up2,
	input  mf3_pkg::pos_t  pos,
	input  logic           adv,
	output logic           win_free,
	output logic           v_s2,
	output mf3_pkg::pix9_t pix9_s2,
	output mf3_pkg::meta_t meta_s2
);

	logic [2:0][2:0][mf3_pkg::PIX_BITS-1:0] win_q;
	logic          em_valid_q;
	logic          xsel_q;
	logic          ysel_q;
	mf3_pkg::pos_t pos_q;
	logic          two_x;
	logic          two_y;
	logic          em_last;
	logic          has_out;
	logic [2:0][1:0] wr;
	logic [2:0][1:0] wc;
	mf3_pkg::pix9_t pick;
	mf3_pkg::meta_t meta;

	assign two_x    = !pos_q.c_is0 && pos_q.c_last;
	assign two_y    = !pos_q.r_is0 && pos_q.r_last;
	assign em_last  = !(!xsel_q && two_x) && !(!ysel_q && two_y);
	assign win_free = !em_valid_q || (adv && em_last);
	assign has_out  = (!pos.c_is0 || pos.c_last) && (!pos.r_is0 || pos.r_last);

	// Neighbors outside the image fall back to the nearest edge pixel.
	always_comb begin
		wr[0] = ysel_q ? (pos_q.r_is0 ? 2'd2 : 2'd1) : (pos_q.r_is1 ? 2'd1 : 2'd0);
		wr[1] = ysel_q ? 2'd2 : 2'd1;
		wr[2] = 2'd2;
		wc[0] = xsel_q ? (pos_q.c_is0 ? 2'd2 : 2'd1) : (pos_q.c_is1 ? 2'd1 : 2'd0);
		wc[1] = xsel_q ? 2'd2 : 2'd1;
		wc[2] = 2'd2;
		for (int dy = 0; dy < 3; dy++) begin
			for (int dx = 0; dx < 3; dx++) begin
				pick[dy * 3 + dx] = win_q[wr[dy]][wc[dx]];
			end
		end
		meta.col        = xsel_q ? pos_q.col : pos_q.col - 1'b1;
		meta.row        = ysel_q ? pos_q.row : pos_q.row - 1'b1;
		meta.run_last   = em_last;
		meta.frame_last = xsel_q && ysel_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			em_valid_q <= 1'b0;
			xsel_q     <= 1'b0;
			ysel_q     <= 1'b0;
			pos_q      <= '0;
			v_s2       <= 1'b0;
		end else begin
			if (adv) begin
				v_s2 <= em_valid_q;
			end
			if (load) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= up2;
				win_q[1][2] <= up;
				win_q[2][2] <= px;
				em_valid_q  <= has_out;
				pos_q       <= pos;
				xsel_q      <= pos.c_is0;
				ysel_q      <= pos.r_is0;
			end else if (adv && em_valid_q) begin
				if (em_last) begin
					em_valid_q <= 1'b0;
				end else if (!xsel_q && two_x) begin
					xsel_q <= 1'b1;
				end else begin
					ysel_q <= 1'b1;
					xsel_q <= pos_q.c_is0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix9_s2 <= pick;
			meta_s2 <= meta;
		end
	end

endmodule

>>> rtl/median_filter_3x3_rgb.sv
// Streaming 3x3 median filter on RGB pixels in raster order. One pixel is taken per
// clock unless the window is busy or the output stalls; each result is the per-channel
// fifth smallest of the pixel's 3x3 neighborhood, with neighbors outside the image
// replaced by the nearest edge pixel, and carries its column, row, a flag on the last
// result caused by its input and a flag on the bottom-right pixel. A pixel causes up to
// four results (more than one only at the right column or bottom row); results leave at
// one per clock unless the output stalls, so the input waits for each extra result.
// Two previous rows live in one on-chip memory read once per pixel; three parallel lanes
// sort the red, green and blue samples. Writing image_width or image_height restarts the
// frame.
module median_filter_3x3_rgb (
	input logic       clk,
	input logic       arst_n,
	mf3_pix_if.sink   pix,
	mf3_med_if.source med,
	mf3_cfg_if.sink   cfg
);

	logic [mf3_pkg::CFG_BITS-1:0] width_q;
	logic [mf3_pkg::CFG_BITS-1:0] height_q;
	logic [mf3_pkg::COL_BITS-1:0] col_q;
	logic [mf3_pkg::ROW_BITS-1:0] row_q;
	logic [mf3_pkg::COL_BITS-1:0] last_col;
	logic [mf3_pkg::ROW_BITS-1:0] last_row;
	logic          accept;
	logic          cfg_wr;
	mf3_pkg::pos_t pos;
	logic          s1_valid;
	mf3_pkg::pix_t px_s1;
	mf3_pkg::pos_t pos_s1;
	logic          s1_go;
	logic          win_free;
	logic          adv;
	mf3_pkg::rows_t rd_rows;
	mf3_pkg::rows_t wr_rows;
	logic           v_s2;
	mf3_pkg::pix9_t pix9_s2;
	mf3_pkg::meta_t meta_s2;
	mf3_pkg::meta_t meta_s3;
	mf3_pkg::meta_t meta_s4;
	mf3_pkg::meta_t meta_s5;
	logic           v_s3;
	logic           v_s4;
	logic           v_s5;
	mf3_pkg::chan9_t lane_in [3];
	mf3_pkg::chan_t  lane_med [3];
	logic           out_valid_q;
	mf3_pkg::chan_t red_q;
	mf3_pkg::chan_t green_q;
	mf3_pkg::chan_t blue_q;
	mf3_pkg::meta_t meta_q;

	always_comb begin
		if (width_q == '0) begin
			last_col = '0;
		end else if (width_q > mf3_pkg::CFG_BITS'(mf3_pkg::MAX_WIDTH)) begin
			last_col = mf3_pkg::COL_BITS'(mf3_pkg::MAX_WIDTH - 1);
		end else begin
			last_col = mf3_pkg::COL_BITS'(width_q - 1'b1);
		end
		last_row = (height_q == '0) ? '0 : height_q - 1'b1;
	end

	assign accept    = pix.valid && pix.ready;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;
	assign adv       = !out_valid_q || med.ready;
	assign s1_go     = s1_valid && win_free;
	assign pix.ready = !s1_valid || s1_go;

	always_comb begin
		pos.col    = col_q;
		pos.row    = row_q;
		pos.c_is0  = (col_q == '0);
		pos.c_is1  = (col_q == mf3_pkg::COL_BITS'(1));
		pos.c_last = (col_q == last_col);
		pos.r_is0  = (row_q == '0);
		pos.r_is1  = (row_q == mf3_pkg::ROW_BITS'(1));
		pos.r_last = (row_q == last_row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mf3_pkg::WIDTH_RESET;
			height_q <= mf3_pkg::HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			s1_valid <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg.addr)
					mf3_pkg::REG_IMAGE_WIDTH: begin
						width_q <= cfg.data;
						col_q   <= '0;
						row_q   <= '0;
					end
					mf3_pkg::REG_IMAGE_HEIGHT: begin
						height_q <= cfg.data;
						col_q    <= '0;
						row_q    <= '0;
					end
					default: begin
					end
				endcase
			end else if (accept) begin
				if (pos.c_last) begin
					col_q <= '0;
					row_q <= pos.r_last ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_go) begin
				s1_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1  <= {pix.in_red, pix.in_green, pix.in_blue};
			pos_s1 <= pos;
		end
	end

	assign wr_rows.prev  = px_s1;
	assign wr_rows.prev2 = rd_rows.prev;

	mf3_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.wr_en   (s1_go),
		.wr_addr (pos_s1.col),
		.wr_data (wr_rows),
		.rd_data (rd_rows)
	);

	mf3_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (s1_go),
		.px       (px_s1),
		.up       (rd_rows.prev),
		.up2      (rd_rows.prev2),
		.pos      (pos_s1),
		.adv      (adv),
		.win_free (win_free),
		.v_s2     (v_s2),
		.pix9_s2  (pix9_s2),
		.meta_s2  (meta_s2)
	);

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int t = 0; t < mf3_pkg::TAPS; t++) begin
				lane_in[ch][t] = pix9_s2[t][ch * mf3_pkg::CHANNEL_BITS +: mf3_pkg::CHANNEL_BITS];
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		mf3_median_lane u_lane (
			.clk  (clk),
			.en   (adv),
			.vals (lane_in[g]),
			.med  (lane_med[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
			meta_q  <= meta_s5;
			red_q   <= lane_med[mf3_pkg::CH_RED];
			green_q <= lane_med[mf3_pkg::CH_GREEN];
			blue_q  <= lane_med[mf3_pkg::CH_BLUE];
		end
	end

	assign med.valid      = out_valid_q;
	assign med.med_red    = red_q;
	assign med.med_green  = green_q;
	assign med.med_blue   = blue_q;
	assign med.out_col    = meta_q.col;
	assign med.out_row    = meta_q.row;
	assign med.run_last   = meta_q.run_last;
	assign med.frame_last = meta_q.frame_last;

endmodule

>>> rtl/mf3_checker.sv
module mf3_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              o_valid,
	input logic                              o_ready,
	input logic [mf3_pkg::CHANNEL_BITS-1:0]  o_red,
	input logic [mf3_pkg::CHANNEL_BITS-1:0]  o_green,
	input logic [mf3_pkg::CHANNEL_BITS-1:0]  o_blue,
	input logic [mf3_pkg::COL_BITS-1:0]      o_col,
	input logic [mf3_pkg::ROW_BITS-1:0]      o_row,
	input logic                              o_run_last,
	input logic                              o_frame_last
);

	// A stalled result keeps its values.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_ready |=> o_valid && $stable({o_red, o_green, o_blue, o_col, o_row,
		o_run_last, o_frame_last}))
		else $error("result changed while stalled");

	// The bottom-right pixel is always the final result of its input.
	a_frame_run: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_frame_last |-> o_run_last)
		else $error("frame end without run end");

	// Results of one input follow each other without a gap.
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_ready && !o_run_last |=> o_valid)
		else $error("gap inside a run of results");

endmodule

bind median_filter_3x3_rgb mf3_checker u_mf3_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.o_valid      (med.valid),
	.o_ready      (med.ready),
	.o_red        (med.med_red),
	.o_green      (med.med_green),
	.o_blue       (med.med_blue),
	.o_col        (med.out_col),
	.o_row        (med.out_row),
	.o_run_last   (med.run_last),
	.o_frame_last (med.frame_last)
);
